FILE: sv/ethernet_frame_classifier_top_defines.svh
// Assertion macros shared by the frame classifier RTL.
`ifndef ETHERNET_FRAME_CLASSIFIER_TOP_DEFINES_SVH
`define ETHERNET_FRAME_CLASSIFIER_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define EFC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define EFC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/efc_pkg.sv
// Types, constants and header offsets for the Ethernet frame classifier.
package efc_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int OUT_COUNT_W = 32;
   localparam int OFF_W       = 17;
   localparam int MAC_W       = 48;
   localparam int IP_W        = 32;
   localparam int WORD_W      = 16;

   localparam logic [WORD_W-1:0] TYPE_IPV4    = 16'h0800;
   localparam logic [WORD_W-1:0] TYPE_ARP     = 16'h0806;
   localparam logic [WORD_W-1:0] MAX_8023_LEN = 16'h05DC;
   localparam logic [WORD_W-1:0] WORD_RAW     = 16'hFFFF;
   localparam logic [WORD_W-1:0] WORD_SNAP    = 16'hAAAA;

   localparam logic [OFF_W-1:0] HDR_LEN         = 17'd14;
   localparam logic [OFF_W-1:0] ARP_LEN         = 17'(28 + 14);
   localparam logic [OFF_W-1:0] IPV4_MIN_LEN    = 17'd34;
   localparam logic [OFF_W-1:0] LEN8023_MIN_LEN = 17'd16;

   // Byte offsets within a frame of the header fields: where each starts, its low byte or its end.
   localparam logic [OFF_W-1:0] OFF_SRC_MAC = 17'd6;
   localparam logic [OFF_W-1:0] OFF_TYPE    = 17'd12;
   localparam logic [OFF_W-1:0] OFF_TYPE_LO = 17'd13;
   localparam logic [OFF_W-1:0] OFF_SECOND  = 17'd14;
   localparam logic [OFF_W-1:0] OFF_IP_LEN  = 17'd16;
   localparam logic [OFF_W-1:0] OFF_IP_LO   = 17'd17;
   localparam logic [OFF_W-1:0] OFF_SRC_IP  = 17'd26;
   localparam logic [OFF_W-1:0] OFF_DST_IP  = 17'd30;
   localparam logic [OFF_W-1:0] OFF_IP_END  = 17'd34;

   typedef enum logic [2:0] {
      KIND_IPV4 = 3'd0,
      KIND_ARP  = 3'd1,
      KIND_DIX  = 3'd2,
      KIND_RAW  = 3'd3,
      KIND_SNAP = 3'd4,
      KIND_LLC  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      CLS_DIX  = 2'd0,
      CLS_RAW  = 2'd1,
      CLS_SNAP = 2'd2,
      CLS_LLC  = 2'd3
   } class_type;

   typedef struct packed {
      logic [MAC_W-1:0] dst_mac;
      logic [MAC_W-1:0] src_mac;
      kind_type         kind;
      class_type        cls;
      logic [IP_W-1:0]  src_ip;
      logic [IP_W-1:0]  dst_ip;
      logic [OFF_W-1:0] frame_length;
      logic             short_frame;
   } result_type;

endpackage

FILE: sv/ethernet_frame_classifier_top.sv
// Ethernet frame classifier top level: byte input stage, parser, counters, result register.
//
// The block takes one byte of a stream of back-to-back Ethernet frames per
// item and gives one result item at the last byte of each frame. A result
// carries the destination and source MAC, the frame kind (IPv4, ARP or other
// DIX, raw 802.3, SNAP or LLC), the IPv4 addresses for IPv4 frames (zero
// otherwise), the frame length including the 14-byte header, a running frame
// number and the running count for the frame's class. Frame length comes from
// the type/length word, is the fixed ARP length for ARP frames, or comes from
// the IP total length for IPv4; a length shorter than the header bytes the
// block reads is raised to that minimum and flagged with short_frame. Throughput
// is one byte per clock cycle. A byte passes through an input register and
// then the parse logic, which updates the frame state and, on the last byte,
// loads the result register. The input register keeps taking bytes while a
// result waits, and stalls only when a last byte meets a result register that
// is still full and not being taken.
module ethernet_frame_classifier_top
   import efc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_byte_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [MAC_W-1:0]       rsp_dst_mac,
   output logic [MAC_W-1:0]       rsp_src_mac,
   output logic [2:0]             rsp_frame_kind,
   output logic [IP_W-1:0]        rsp_src_ip,
   output logic [IP_W-1:0]        rsp_dst_ip,
   output logic [OFF_W-1:0]       rsp_frame_length,
   output logic [OUT_COUNT_W-1:0] rsp_frame_number,
   output logic [OUT_COUNT_W-1:0] rsp_class_count,
   output logic                   rsp_short_frame
);

`include "ethernet_frame_classifier_top_defines.svh"

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   rsp_valid_ff;
   logic [MAC_W-1:0]       dst_mac_ff;
   logic [MAC_W-1:0]       src_mac_ff;
   logic [2:0]             kind_ff;
   logic [IP_W-1:0]        src_ip_ff;
   logic [IP_W-1:0]        dst_ip_ff;
   logic [OFF_W-1:0]       length_ff;
   logic [OUT_COUNT_W-1:0] number_ff;
   logic [OUT_COUNT_W-1:0] class_count_ff;
   logic                   short_ff;

   logic                   frame_done;
   result_type             result;
   logic                   out_free;
   logic                   advance;
   logic                   load_result;
   logic [OUT_COUNT_W-1:0] frame_number;
   logic [OUT_COUNT_W-1:0] class_count;

   // The buffered byte moves on unless it finishes a frame and the result
   // register cannot take the new result in this cycle.
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && (!frame_done || out_free);
   assign load_result = advance && frame_done;
   assign req_ready   = !in_valid_ff || advance;

   efc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .data_byte (in_byte_ff),
      .done      (frame_done),
      .result    (result)
   );

   efc_stats u_stats (
      .clock        (clock),
      .reset        (reset),
      .count        (load_result),
      .cls          (result.cls),
      .frame_number (frame_number),
      .class_count  (class_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         dst_mac_ff     <= result.dst_mac;
         src_mac_ff     <= result.src_mac;
         kind_ff        <= result.kind;
         src_ip_ff      <= result.src_ip;
         dst_ip_ff      <= result.dst_ip;
         length_ff      <= result.frame_length;
         number_ff      <= frame_number;
         class_count_ff <= class_count;
         short_ff       <= result.short_frame;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dst_mac      = dst_mac_ff;
   assign rsp_src_mac      = src_mac_ff;
   assign rsp_frame_kind   = kind_ff;
   assign rsp_src_ip       = src_ip_ff;
   assign rsp_dst_ip       = dst_ip_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_frame_number = number_ff;
   assign rsp_class_count  = class_count_ff;
   assign rsp_short_frame  = short_ff;

   `EFC_ASSERT(a_byte_held, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)), "buffered byte lost while stalled")
   `EFC_ASSERT(a_no_overwrite, (rsp_valid_ff && !rsp_ready) |-> !load_result, "result register overwritten before it was taken")
   `EFC_ASSERT_ALWAYS(a_reset_empty, reset |=> (!in_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule

FILE: sv/efc_parse.sv
// Header capture, length tracking and classification of the byte stream.
module efc_parse
   import efc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [7:0]       data_byte,
   output logic             done,
   output result_type       result
);

`include "ethernet_frame_classifier_top_defines.svh"

   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic [OFF_W-1:0]  goal_ff, goal_in;
   logic [MAC_W-1:0]  dst_mac_ff, dst_mac_in;
   logic [MAC_W-1:0]  src_mac_ff, src_mac_in;
   logic [WORD_W-1:0] type_ff, type_in;
   logic [WORD_W-1:0] second_ff, second_in;
   logic [IP_W-1:0]   src_ip_ff, src_ip_in;
   logic [IP_W-1:0]   dst_ip_ff, dst_ip_in;
   logic [7:0]        ip_len_high_ff, ip_len_high_in;
   logic              short_ff, short_in;
   logic [OFF_W-1:0]  type_len;
   logic [OFF_W-1:0]  ip_len;
   logic [OFF_W-1:0]  offset_next;

   always_comb begin
      dst_mac_in     = dst_mac_ff;
      src_mac_in     = src_mac_ff;
      type_in        = type_ff;
      second_in      = second_ff;
      ip_len_high_in = ip_len_high_ff;
      src_ip_in      = src_ip_ff;
      dst_ip_in      = dst_ip_ff;

      priority if (offset_ff < OFF_SRC_MAC) begin
         dst_mac_in = {dst_mac_ff[MAC_W-9:0], data_byte};
      end else if (offset_ff < OFF_TYPE) begin
         src_mac_in = {src_mac_ff[MAC_W-9:0], data_byte};
      end else if (offset_ff < OFF_SECOND) begin
         type_in = {type_ff[WORD_W-9:0], data_byte};
      end else if (offset_ff < OFF_IP_LEN) begin
         second_in = {second_ff[WORD_W-9:0], data_byte};
      end else if (offset_ff == OFF_IP_LEN) begin
         ip_len_high_in = data_byte;
      end else if (offset_ff >= OFF_SRC_IP && offset_ff < OFF_DST_IP) begin
         src_ip_in = {src_ip_ff[IP_W-9:0], data_byte};
      end else if (offset_ff >= OFF_DST_IP && offset_ff < OFF_IP_END) begin
         dst_ip_in = {dst_ip_ff[IP_W-9:0], data_byte};
      end else begin
         dst_mac_in = dst_mac_ff;
      end
   end

   // The frame length becomes known at the type word, or at the IP total
   // length for IPv4 frames.
   always_comb begin
      type_len = OFF_W'(type_in) + HDR_LEN;
      ip_len   = OFF_W'({ip_len_high_ff, data_byte}) + HDR_LEN;
      goal_in  = goal_ff;
      short_in = short_ff;
      if (offset_ff == OFF_TYPE_LO && type_in != TYPE_IPV4) begin
         priority if (type_in == TYPE_ARP) begin
            goal_in = ARP_LEN;
         end else if (type_in > MAX_8023_LEN) begin
            goal_in = type_len;
         end else if (type_len < LEN8023_MIN_LEN) begin
            goal_in  = LEN8023_MIN_LEN;
            short_in = 1'b1;
         end else begin
            goal_in = type_len;
         end
      end else if (offset_ff == OFF_IP_LO && type_in == TYPE_IPV4) begin
         if (ip_len < IPV4_MIN_LEN) begin
            goal_in  = IPV4_MIN_LEN;
            short_in = 1'b1;
         end else begin
            goal_in = ip_len;
         end
      end
      offset_next = offset_ff + OFF_W'(1);
      done        = (goal_in != '0) && (offset_next == goal_in);
      offset_in   = done ? '0 : offset_next;
   end

   always_comb begin
      result.dst_mac      = dst_mac_in;
      result.src_mac      = src_mac_in;
      result.src_ip       = '0;
      result.dst_ip       = '0;
      result.frame_length = goal_in;
      result.short_frame  = short_in;
      priority if (type_in == TYPE_IPV4) begin
         result.kind   = KIND_IPV4;
         result.cls    = CLS_DIX;
         result.src_ip = src_ip_in;
         result.dst_ip = dst_ip_in;
      end else if (type_in == TYPE_ARP) begin
         result.kind = KIND_ARP;
         result.cls  = CLS_DIX;
      end else if (type_in > MAX_8023_LEN) begin
         result.kind = KIND_DIX;
         result.cls  = CLS_DIX;
      end else if (second_in == WORD_RAW) begin
         result.kind = KIND_RAW;
         result.cls  = CLS_RAW;
      end else if (second_in == WORD_SNAP) begin
         result.kind = KIND_SNAP;
         result.cls  = CLS_SNAP;
      end else begin
         result.kind = KIND_LLC;
         result.cls  = CLS_LLC;
      end
   end

   // A finished frame clears all per-frame state for the next one.
   always_ff @(posedge clock) begin
      if (reset || (enable && done)) begin
         offset_ff      <= '0;
         goal_ff        <= '0;
         dst_mac_ff     <= '0;
         src_mac_ff     <= '0;
         type_ff        <= '0;
         second_ff      <= '0;
         src_ip_ff      <= '0;
         dst_ip_ff      <= '0;
         ip_len_high_ff <= '0;
         short_ff       <= 1'b0;
      end else if (enable) begin
         offset_ff      <= offset_in;
         goal_ff        <= goal_in;
         dst_mac_ff     <= dst_mac_in;
         src_mac_ff     <= src_mac_in;
         type_ff        <= type_in;
         second_ff      <= second_in;
         src_ip_ff      <= src_ip_in;
         dst_ip_ff      <= dst_ip_in;
         ip_len_high_ff <= ip_len_high_in;
         short_ff       <= short_in;
      end
   end

   `EFC_ASSERT(a_offset_clears, (enable && done) |=> (offset_ff == '0 && goal_ff == '0), "frame state not cleared after last byte")
   `EFC_ASSERT(a_goal_ahead, (goal_ff != '0) |-> (goal_ff > offset_ff), "frame length behind the byte offset")
   `EFC_ASSERT(a_short_kind, short_ff |-> (type_ff == TYPE_IPV4 || type_ff <= MAX_8023_LEN), "short flag on a frame kind that cannot be short")

endmodule

FILE: sv/efc_stats.sv
// Running frame counter and per-class frame counters.
module efc_stats
   import efc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   count,
   input  class_type              cls,
   output logic [OUT_COUNT_W-1:0] frame_number,
   output logic [OUT_COUNT_W-1:0] class_count
);

   logic [COUNT_WIDTH-1:0] frame_counter_ff, frame_counter_in;
   logic [COUNT_WIDTH-1:0] class_counters_ff [4];
   logic [COUNT_WIDTH-1:0] class_counter_in;

   // Results show the counts including the frame being reported.
   assign frame_counter_in = frame_counter_ff + COUNT_WIDTH'(1);
   assign class_counter_in = class_counters_ff[cls] + COUNT_WIDTH'(1);
   assign frame_number     = OUT_COUNT_W'(frame_counter_in);
   assign class_count      = OUT_COUNT_W'(class_counter_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_counter_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            class_counters_ff[i] <= '0;
         end
      end else if (count) begin
         frame_counter_ff       <= frame_counter_in;
         class_counters_ff[cls] <= class_counter_in;
      end
   end

endmodule
